### rtl/abtt_pkg.sv
// ----------------------------------------------------------------------------
// abtt_pkg: shared constants for the alpha-beta target tracker
// Quantity codes, register indexes, frame phase codes and fixed field widths.
// ----------------------------------------------------------------------------
package abtt_pkg;

  // fixed field widths
  localparam int LEVEL_W   = 16;
  localparam int QTY_W     = 4;
  localparam int NUM_QTY   = 12;
  localparam int NUM_POS   = 5;
  localparam int POS_IDX_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int PHASE_W   = 3;

  // result quantity codes
  localparam logic [QTY_W-1:0] QTY_CX     = 4'd0;
  localparam logic [QTY_W-1:0] QTY_CY     = 4'd1;
  localparam logic [QTY_W-1:0] QTY_PX     = 4'd2;
  localparam logic [QTY_W-1:0] QTY_PY     = 4'd3;
  localparam logic [QTY_W-1:0] QTY_PZ     = 4'd4;
  localparam logic [QTY_W-1:0] QTY_AREA   = 4'd5;
  localparam logic [QTY_W-1:0] QTY_ASPECT = 4'd6;
  localparam logic [QTY_W-1:0] QTY_THRESH = 4'd7;
  localparam logic [QTY_W-1:0] QTY_BOXX   = 4'd8;
  localparam logic [QTY_W-1:0] QTY_BOXY   = 4'd9;
  localparam logic [QTY_W-1:0] QTY_W_BOX  = 4'd10;
  localparam logic [QTY_W-1:0] QTY_H_BOX  = 4'd11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEIL  = 1'd1;

  // frame phase codes
  localparam logic [PHASE_W-1:0] PHASE_FIRST    = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_UNIT     = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_FAST_END = 3'd5;
  localparam logic [PHASE_W-1:0] PHASE_STEADY   = 3'd6;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

endpackage

### rtl/abtt_scale.sv
// ----------------------------------------------------------------------------
// abtt_scale: registered fixed-point gain multiply
// Computes round(err * gain / 2^F), ties toward +infinity, one register deep.
// ----------------------------------------------------------------------------
module abtt_scale #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] err_i,
  input  logic [F:0]   gain_i,
  output logic [W:0]   prod_o
);

  localparam int PW = W + F + 2;

  logic signed [PW-1:0] err_ext;
  logic signed [PW-1:0] gain_ext;
  logic signed [PW-1:0] full;
  logic signed [PW-1:0] rounded;
  logic        [W:0]    prod_d;
  logic        [W:0]    prod_q;

  assign err_ext  = PW'($signed(err_i));
  assign gain_ext = $signed(PW'(gain_i));
  assign full     = err_ext * gain_ext;
  // add half an lsb before dropping the fraction
  assign rounded  = full + (PW'(1) << (F - 1));
  assign prod_d   = rounded[F +: W + 1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/alpha_beta_target_tracker.sv
// ----------------------------------------------------------------------------
// alpha_beta_target_tracker: fading-memory alpha-beta tracker, one object
// Takes one measurement item per frame and returns twelve result items.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid_i / in_ready_o carries one measurement item.
//   output channel out_valid_o / out_ready_i carries result items, quantity
//   0 to 11 in order, last_o high on the twelfth item of a frame.
//   cfg channel writes threshold_floor (index 0) and threshold_ceiling
//   (index 1); cfg_ready_o is always high.
// Timing:
//   the update engine walks six steps (predict, error, multiply, update,
//   corner difference, corner), and the result frame register is loaded
//   from the corner step.
//   a frame of results drains at one item per cycle while out_ready_i is high;
//   the next item is accepted and processed while the previous frame still
//   drains, and waits in the corner step until the result frame register is
//   free.
// Reset:
//   clears the tracked state and frame phase, floor to 0, ceiling to 65535.
// Stall:
//   a low out_ready_i holds the current result item; the engine then holds
//   its finished item and in_ready_o stays low.
// ----------------------------------------------------------------------------
module alpha_beta_target_tracker #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // measurement items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [VALUE_WIDTH-1:0]           meas_cx_i,
  input  logic [VALUE_WIDTH-1:0]           meas_cy_i,
  input  logic [VALUE_WIDTH-1:0]           meas_px_i,
  input  logic [VALUE_WIDTH-1:0]           meas_py_i,
  input  logic [VALUE_WIDTH-1:0]           meas_pz_i,
  input  logic [VALUE_WIDTH-1:0]           meas_area_i,
  input  logic [VALUE_WIDTH-1:0]           meas_aspect_i,
  input  logic [abtt_pkg::LEVEL_W-1:0]     meas_level_i,
  input  logic [VALUE_WIDTH-1:0]           meas_box_x_i,
  input  logic [VALUE_WIDTH-1:0]           meas_box_y_i,
  input  logic [VALUE_WIDTH-1:0]           meas_box_w_i,
  input  logic [VALUE_WIDTH-1:0]           meas_box_h_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [abtt_pkg::QTY_W-1:0]       quantity_o,
  output logic [VALUE_WIDTH-1:0]           estimate_o,
  output logic [VALUE_WIDTH-1:0]           rate_o,
  output logic                             last_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [abtt_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [abtt_pkg::LEVEL_W-1:0]     cfg_data_i
);

  localparam int VW  = VALUE_WIDTH;
  localparam int SW  = VALUE_WIDTH + 2;
  localparam int GW  = FRAC_BITS + 1;
  localparam int LW  = abtt_pkg::LEVEL_W;
  localparam int NP  = abtt_pkg::NUM_POS;
  localparam int NQ  = abtt_pkg::NUM_QTY;

  localparam logic [VW-1:0] VMIN = VW'(1) << (VW - 1);
  localparam logic [VW-1:0] VMAX = ~VMIN;

  // gains in Q with FRAC_BITS fraction bits, rounded to nearest
  localparam longint ONE_Q = longint'(1) << FRAC_BITS;
  localparam logic [GW-1:0] G_ONE  = GW'(ONE_Q);
  localparam logic [GW-1:0] G_HALF = GW'(ONE_Q / 2);
  localparam logic [GW-1:0] G_3Q   = GW'(3 * ONE_Q / 4);
  localparam logic [GW-1:0] G_1Q   = GW'(ONE_Q / 4);
  localparam logic [GW-1:0] G_0P2  = GW'((ONE_Q + 2) / 5);
  localparam logic [GW-1:0] G_0P36 = GW'((9 * ONE_Q + 12) / 25);
  localparam logic [GW-1:0] G_0P04 = GW'((ONE_Q + 12) / 25);
  localparam logic [GW-1:0] G_0P3  = GW'((3 * ONE_Q + 5) / 10);

  // engine steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] ST_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] ST_PRED = 3'd1;
  localparam logic [STEP_W-1:0] ST_ERR  = 3'd2;
  localparam logic [STEP_W-1:0] ST_MUL  = 3'd3;
  localparam logic [STEP_W-1:0] ST_UPD  = 3'd4;
  localparam logic [STEP_W-1:0] ST_DIFF = 3'd5;
  localparam logic [STEP_W-1:0] ST_BOX  = 3'd6;

  function automatic logic [VW-1:0] sat_v(input logic [SW-1:0] v);
    logic [VW-1:0] r;
    if (v[SW-1:VW-1] == '0 || v[SW-1:VW-1] == '1) begin
      r = v[VW-1:0];
    end else if (v[SW-1]) begin
      r = VMIN;
    end else begin
      r = VMAX;
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] sx(input logic [VW-1:0] a);
    return {{2{a[VW-1]}}, a};
  endfunction

  function automatic logic [SW-1:0] sxp(input logic [VW:0] a);
    return {a[VW], a};
  endfunction

  // configuration
  logic [LW-1:0] floor_q, ceil_q;

  // measurement register
  logic [VW-1:0] m_pos_q [NP];
  logic [VW-1:0] m_area_q, m_aspect_q, m_bx_q, m_by_q, m_w_q, m_h_q;
  logic [LW-1:0] m_level_q;

  // tracked state
  logic [VW-1:0]            pos_q [NP];
  logic [VW-1:0]            vel_q [NP];
  logic [VW-1:0]            area_q, aspect_q;
  logic [LW-1:0]            level_q;
  logic [abtt_pkg::PHASE_W-1:0] phase_q;

  // engine registers
  logic [STEP_W-1:0] step_q, step_d;
  logic [VW-1:0]     pred_q [NP];
  logic [VW-1:0]     perr_q [NP];
  logic [VW-1:0]     aerr_q, serr_q;
  logic [LW:0]       lerr_q;
  logic [VW-1:0]     diff_x_q, diff_y_q;

  // products
  logic [VW:0] pa [NP];
  logic [VW:0] pb [NP];
  logic [VW:0] pk_area, pk_aspect;
  logic [LW+1:0] pt_level;

  // result frame
  logic [VW-1:0]              fr_est_q  [NQ];
  logic [VW-1:0]              fr_rate_q [NP];
  logic [abtt_pkg::QTY_W-1:0] out_idx_q;
  logic                       out_valid_q;

  logic          in_acc, frame_free, load;
  logic [GW-1:0] ga, gb, gk, gt;
  logic [VW-1:0] box_x, box_y;
  logic [LW+2:0] lv_sum;
  logic [LW-1:0] lv_clip, lv_new;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0;
      ceil_q  <= abtt_pkg::LEVEL_MAX;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        abtt_pkg::CFG_FLOOR: floor_q <= cfg_data_i;
        abtt_pkg::CFG_CEIL:  ceil_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and step control
  // ---------------------------------------------------------------------------
  assign frame_free = !out_valid_q || (out_ready_i && out_idx_q == abtt_pkg::QTY_H_BOX);
  assign load       = (step_q == ST_BOX) && frame_free;
  assign in_ready_o = (step_q == ST_IDLE) || load;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      ST_IDLE: if (in_acc) step_d = ST_PRED;
      ST_PRED: step_d = ST_ERR;
      ST_ERR:  step_d = ST_MUL;
      ST_MUL:  step_d = ST_UPD;
      ST_UPD:  step_d = ST_DIFF;
      ST_DIFF: step_d = ST_BOX;
      ST_BOX: begin
        if (load) begin
          step_d = in_acc ? ST_PRED : ST_IDLE;
        end
      end
      default: step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      m_pos_q[0] <= meas_cx_i;
      m_pos_q[1] <= meas_cy_i;
      m_pos_q[2] <= meas_px_i;
      m_pos_q[3] <= meas_py_i;
      m_pos_q[4] <= meas_pz_i;
      m_area_q   <= meas_area_i;
      m_aspect_q <= meas_aspect_i;
      m_level_q  <= meas_level_i;
      m_bx_q     <= meas_box_x_i;
      m_by_q     <= meas_box_y_i;
      m_w_q      <= meas_box_w_i;
      m_h_q      <= meas_box_h_i;
    end
  end

  // ---------------------------------------------------------------------------
  // gains by frame phase
  // ---------------------------------------------------------------------------
  always_comb begin
    if (phase_q <= abtt_pkg::PHASE_UNIT) begin
      ga = G_ONE;
      gb = G_ONE;
      gk = G_ONE;
      gt = '0;
    end else if (phase_q <= abtt_pkg::PHASE_FAST_END) begin
      ga = G_3Q;
      gb = G_1Q;
      gk = G_HALF;
      gt = G_HALF;
    end else begin
      ga = G_0P36;
      gb = G_0P04;
      gk = G_0P2;
      gt = G_0P3;
    end
  end

  // ---------------------------------------------------------------------------
  // predict, error and corner difference steps
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (step_q == ST_PRED) begin
      for (int i = 0; i < NP; i++) begin
        pred_q[i] <= sat_v(sx(pos_q[i]) + sx(vel_q[i]));
      end
      aerr_q <= sat_v(sx(m_area_q) - sx(area_q));
      serr_q <= sat_v(sx(m_aspect_q) - sx(aspect_q));
      lerr_q <= {1'b0, m_level_q} - {1'b0, level_q};
    end
    if (step_q == ST_ERR) begin
      for (int i = 0; i < NP; i++) begin
        perr_q[i] <= sat_v(sx(m_pos_q[i]) - sx(pred_q[i]));
      end
    end
    // measured centre minus the new estimate, for the box corner
    if (step_q == ST_DIFF) begin
      diff_x_q <= sat_v(sx(m_pos_q[0]) - sx(pos_q[0]));
      diff_y_q <= sat_v(sx(m_pos_q[1]) - sx(pos_q[1]));
    end
  end

  // ---------------------------------------------------------------------------
  // gain multipliers
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NP; g++) begin : g_pos_mul
    abtt_scale #(.W(VW), .F(FRAC_BITS)) u_alpha (
      .clk_i  (clk_i),
      .en_i   (step_q == ST_MUL),
      .err_i  (perr_q[g]),
      .gain_i (ga),
      .prod_o (pa[g])
    );
    abtt_scale #(.W(VW), .F(FRAC_BITS)) u_beta (
      .clk_i  (clk_i),
      .en_i   (step_q == ST_MUL),
      .err_i  (perr_q[g]),
      .gain_i (gb),
      .prod_o (pb[g])
    );
  end

  abtt_scale #(.W(VW), .F(FRAC_BITS)) u_area (
    .clk_i  (clk_i),
    .en_i   (step_q == ST_MUL),
    .err_i  (aerr_q),
    .gain_i (gk),
    .prod_o (pk_area)
  );

  abtt_scale #(.W(VW), .F(FRAC_BITS)) u_aspect (
    .clk_i  (clk_i),
    .en_i   (step_q == ST_MUL),
    .err_i  (serr_q),
    .gain_i (gk),
    .prod_o (pk_aspect)
  );

  abtt_scale #(.W(LW + 1), .F(FRAC_BITS)) u_level (
    .clk_i  (clk_i),
    .en_i   (step_q == ST_MUL),
    .err_i  (lerr_q),
    .gain_i (gt),
    .prod_o (pt_level)
  );

  // ---------------------------------------------------------------------------
  // threshold update with clamps, ceiling first so a high floor wins
  // ---------------------------------------------------------------------------
  assign lv_sum = {3'b000, level_q} + {pt_level[LW+1], pt_level};

  always_comb begin
    if (lv_sum[LW+2]) begin
      lv_clip = '0;
    end else if (lv_sum[LW+1:LW] != 2'b00) begin
      lv_clip = abtt_pkg::LEVEL_MAX;
    end else begin
      lv_clip = lv_sum[LW-1:0];
    end
    lv_new = lv_clip;
    if (lv_new > ceil_q) begin
      lv_new = ceil_q;
    end
    if (lv_new < floor_q) begin
      lv_new = floor_q;
    end
  end

  // ---------------------------------------------------------------------------
  // state update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NP; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
      area_q   <= '0;
      aspect_q <= '0;
      level_q  <= '0;
      phase_q  <= abtt_pkg::PHASE_FIRST;
    end else if (step_q == ST_UPD) begin
      if (phase_q == abtt_pkg::PHASE_FIRST) begin
        // first frame copies the measurement
        for (int i = 0; i < NP; i++) begin
          pos_q[i] <= m_pos_q[i];
          vel_q[i] <= '0;
        end
        area_q   <= m_area_q;
        aspect_q <= m_aspect_q;
        level_q  <= m_level_q;
      end else begin
        for (int i = 0; i < NP; i++) begin
          pos_q[i] <= sat_v(sx(pred_q[i]) + sxp(pa[i]));
          vel_q[i] <= sat_v(sx(vel_q[i]) + sxp(pb[i]));
        end
        area_q   <= sat_v(sx(area_q) + sxp(pk_area));
        aspect_q <= sat_v(sx(aspect_q) + sxp(pk_aspect));
        level_q  <= lv_new;
      end
      if (phase_q != abtt_pkg::PHASE_STEADY) begin
        phase_q <= phase_q + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result frame and serializer
  // ---------------------------------------------------------------------------
  assign box_x = sat_v(sx(m_bx_q) - sx(diff_x_q));
  assign box_y = sat_v(sx(m_by_q) - sx(diff_y_q));

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NP; i++) begin
        fr_est_q[i]  <= pos_q[i];
        fr_rate_q[i] <= vel_q[i];
      end
      fr_est_q[abtt_pkg::QTY_AREA]   <= area_q;
      fr_est_q[abtt_pkg::QTY_ASPECT] <= aspect_q;
      fr_est_q[abtt_pkg::QTY_THRESH] <= VW'(level_q);
      fr_est_q[abtt_pkg::QTY_BOXX]   <= box_x;
      fr_est_q[abtt_pkg::QTY_BOXY]   <= box_y;
      fr_est_q[abtt_pkg::QTY_W_BOX]  <= m_w_q;
      fr_est_q[abtt_pkg::QTY_H_BOX]  <= m_h_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_idx_q   <= abtt_pkg::QTY_CX;
    end else if (load) begin
      out_valid_q <= 1'b1;
      out_idx_q   <= abtt_pkg::QTY_CX;
    end else if (out_valid_q && out_ready_i) begin
      if (out_idx_q == abtt_pkg::QTY_H_BOX) begin
        out_valid_q <= 1'b0;
        out_idx_q   <= abtt_pkg::QTY_CX;
      end else begin
        out_idx_q <= out_idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign quantity_o  = out_idx_q;
  assign estimate_o  = fr_est_q[out_idx_q];
  assign rate_o      = (out_idx_q <= abtt_pkg::QTY_PZ)
                     ? fr_rate_q[out_idx_q[abtt_pkg::POS_IDX_W-1:0]] : '0;
  assign last_o      = (out_idx_q == abtt_pkg::QTY_H_BOX);

endmodule
